@@ sv/lpg_pkg.sv @@
// shared types and constants of the line pixel generator
// no dependencies; imported by every module of the block
package lpg_pkg;

   localparam int COORD_BITS_DEF = 15;
   localparam int WIDTH_BITS     = 16;
   localparam int HEIGHT_BITS    = 8;
   localparam int COLOR_BITS     = 16;
   localparam int ADDR_BITS      = 24;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RESET  = 16'd320;
   localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RESET = 8'd240;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      FUNC_START   = 1'b0,
      FUNC_ADVANCE = 1'b1
   } func_type;

   // qualified commands from the input handshake
   typedef struct packed {
      logic start;
      logic advance;
   } lpg_cmd_type;

endpackage

@@ sv/lpg_setup.sv @@
// line setup: steep swap, endpoint ordering and deltas for a new line
// depends on lpg_pkg
module lpg_setup #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic signed [COORD_BITS-1:0] start_x,
   input  logic signed [COORD_BITS-1:0] start_y,
   input  logic signed [COORD_BITS-1:0] end_x,
   input  logic signed [COORD_BITS-1:0] end_y,
   output logic                         steep,
   output logic signed [COORD_BITS-1:0] major_pos,
   output logic signed [COORD_BITS-1:0] major_end,
   output logic signed [COORD_BITS-1:0] minor_pos,
   output logic        [COORD_BITS-1:0] major_delta,
   output logic        [COORD_BITS-1:0] minor_delta,
   output logic                         step_down
);
   import lpg_pkg::*;

   localparam int DW = COORD_BITS + 1;

   logic signed [DW-1:0] ax, ay, bx, by;
   logic signed [DW-1:0] adx, ady;
   logic signed [DW-1:0] sax, say, sbx, sby;
   logic signed [DW-1:0] oax, oay, obx, oby;
   logic signed [DW-1:0] dmaj, dmin;

   always_comb begin
      ax = DW'(start_x);
      ay = DW'(start_y);
      bx = DW'(end_x);
      by = DW'(end_y);
      adx = (bx > ax) ? bx - ax : ax - bx;
      ady = (by > ay) ? by - ay : ay - by;
      steep = ady > adx;
      if (steep) begin
         sax = ay; say = ax; sbx = by; sby = bx;
      end else begin
         sax = ax; say = ay; sbx = bx; sby = by;
      end
      if (sax > sbx) begin
         oax = sbx; oay = sby; obx = sax; oby = say;
      end else begin
         oax = sax; oay = say; obx = sbx; oby = sby;
      end
      dmaj = obx - oax;
      dmin = (oby > oay) ? oby - oay : oay - oby;
      major_pos   = oax[COORD_BITS-1:0];
      major_end   = obx[COORD_BITS-1:0];
      minor_pos   = oay[COORD_BITS-1:0];
      major_delta = dmaj[COORD_BITS-1:0];
      minor_delta = dmin[COORD_BITS-1:0];
      step_down   = !(oay < oby);
   end

endmodule

@@ sv/lpg_stepper.sv @@
// line state registers and the per-pixel error update
// depends on lpg_pkg and lpg_setup
module lpg_stepper #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lpg_pkg::lpg_cmd_type               cmd,
   input  logic signed [COORD_BITS-1:0]       start_x,
   input  logic signed [COORD_BITS-1:0]       start_y,
   input  logic signed [COORD_BITS-1:0]       end_x,
   input  logic signed [COORD_BITS-1:0]       end_y,
   input  logic [lpg_pkg::COLOR_BITS-1:0]     color,
   output logic                               busy,
   output logic signed [COORD_BITS-1:0]       pixel_x,
   output logic signed [COORD_BITS-1:0]       pixel_y,
   output logic                               last,
   output logic [lpg_pkg::COLOR_BITS-1:0]     line_color
);
   import lpg_pkg::*;

   localparam int EW = COORD_BITS + 2;
   // unit step along either axis
   localparam logic signed [COORD_BITS-1:0] COORD_ONE = COORD_BITS'(1);

   logic busy_ff, busy_in;
   logic steep_ff, steep_in;
   logic signed [COORD_BITS-1:0] major_pos_ff, major_pos_in;
   logic signed [COORD_BITS-1:0] major_end_ff, major_end_in;
   logic signed [COORD_BITS-1:0] minor_pos_ff, minor_pos_in;
   logic [COORD_BITS-1:0] major_delta_ff, major_delta_in;
   logic [COORD_BITS-1:0] minor_delta_ff, minor_delta_in;
   logic signed [EW-1:0] error_ff, error_in;
   logic step_down_ff, step_down_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic s_steep, s_step_down;
   logic signed [COORD_BITS-1:0] s_major_pos, s_major_end, s_minor_pos;
   logic [COORD_BITS-1:0] s_major_delta, s_minor_delta;
   logic signed [EW-1:0] error_sub;
   logic step;

   lpg_setup #(.COORD_BITS(COORD_BITS)) u_setup (
      .start_x     (start_x),
      .start_y     (start_y),
      .end_x       (end_x),
      .end_y       (end_y),
      .steep       (s_steep),
      .major_pos   (s_major_pos),
      .major_end   (s_major_end),
      .minor_pos   (s_minor_pos),
      .major_delta (s_major_delta),
      .minor_delta (s_minor_delta),
      .step_down   (s_step_down)
   );

   assign step = cmd.advance && busy_ff;
   assign last = major_pos_ff >= major_end_ff;
   assign error_sub = error_ff - $signed({2'b00, minor_delta_ff});

   always_comb begin
      busy_in        = busy_ff;
      steep_in       = steep_ff;
      major_pos_in   = major_pos_ff;
      major_end_in   = major_end_ff;
      minor_pos_in   = minor_pos_ff;
      major_delta_in = major_delta_ff;
      minor_delta_in = minor_delta_ff;
      error_in       = error_ff;
      step_down_in   = step_down_ff;
      color_in       = color_ff;
      if (cmd.start) begin
         busy_in        = 1'b1;
         steep_in       = s_steep;
         major_pos_in   = s_major_pos;
         major_end_in   = s_major_end;
         minor_pos_in   = s_minor_pos;
         major_delta_in = s_major_delta;
         minor_delta_in = s_minor_delta;
         error_in       = $signed({2'b00, s_major_delta >> 1});
         step_down_in   = s_step_down;
         color_in       = color;
      end else if (step) begin
         error_in = error_sub;
         if (error_sub < 0) begin
            minor_pos_in = step_down_ff ? minor_pos_ff - COORD_ONE : minor_pos_ff + COORD_ONE;
            error_in     = error_sub + $signed({2'b00, major_delta_ff});
         end
         if (last) begin
            busy_in = 1'b0;
         end else begin
            major_pos_in = major_pos_ff + COORD_ONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      steep_ff       <= steep_in;
      major_pos_ff   <= major_pos_in;
      major_end_ff   <= major_end_in;
      minor_pos_ff   <= minor_pos_in;
      major_delta_ff <= major_delta_in;
      minor_delta_ff <= minor_delta_in;
      error_ff       <= error_in;
      step_down_ff   <= step_down_in;
      color_ff       <= color_in;
   end

   assign busy       = busy_ff;
   assign pixel_x    = steep_ff ? minor_pos_ff : major_pos_ff;
   assign pixel_y    = steep_ff ? major_pos_ff : minor_pos_ff;
   assign line_color = color_ff;

endmodule

@@ sv/lpg_pixel.sv @@
// pixel result stage: clipping, address multiply and the result register
// depends on lpg_pkg
module lpg_pixel #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              emit,
   input  logic                              out_ready,
   input  logic signed [COORD_BITS-1:0]      pixel_x,
   input  logic signed [COORD_BITS-1:0]      pixel_y,
   input  logic                              last,
   input  logic [lpg_pkg::COLOR_BITS-1:0]    line_color,
   input  logic [lpg_pkg::WIDTH_BITS-1:0]    frame_width,
   input  logic [lpg_pkg::HEIGHT_BITS-1:0]   frame_height,
   output logic                              out_valid,
   output logic                              slot_free,
   output logic signed [COORD_BITS-1:0]      out_x,
   output logic signed [COORD_BITS-1:0]      out_y,
   output logic [lpg_pkg::ADDR_BITS-1:0]     out_address,
   output logic [lpg_pkg::COLOR_BITS-1:0]    out_color,
   output logic                              out_write_enable,
   output logic                              out_last
);
   import lpg_pkg::*;

   logic valid_ff, valid_in;
   logic signed [COORD_BITS-1:0] x_ff, y_ff;
   logic [ADDR_BITS-1:0] address_ff, address_in;
   logic [COLOR_BITS-1:0] color_ff;
   logic we_ff, in_frame;
   logic last_ff;

   logic [COORD_BITS-2:0] x_mag, y_mag;
   logic [HEIGHT_BITS+WIDTH_BITS-1:0] row_base;

   assign x_mag = pixel_x[COORD_BITS-2:0];
   assign y_mag = pixel_y[COORD_BITS-2:0];

   always_comb begin
      in_frame = !pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1] &&
                 (WIDTH_BITS'(x_mag) < frame_width) &&
                 (COORD_BITS'(y_mag) < COORD_BITS'(frame_height));
      // row is below the frame height when inside, so 8 bits carry it
      row_base   = HEIGHT_BITS'(y_mag) * frame_width;
      address_in = in_frame ? ADDR_BITS'(row_base) + ADDR_BITS'(x_mag) : '0;
   end

   assign slot_free = !valid_ff || out_ready;
   assign valid_in  = emit ? 1'b1 : (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (emit) begin
         x_ff       <= pixel_x;
         y_ff       <= pixel_y;
         address_ff <= address_in;
         color_ff   <= line_color;
         we_ff      <= in_frame;
         last_ff    <= last;
      end
   end

   assign out_valid        = valid_ff;
   assign out_x            = x_ff;
   assign out_y            = y_ff;
   assign out_address      = address_ff;
   assign out_color        = color_ff;
   assign out_write_enable = we_ff;
   assign out_last         = last_ff;

endmodule

@@ sv/line_pixel_generator_top.sv @@
// top level of the line pixel generator: stream ports, frame registers
// depends on lpg_pkg, lpg_stepper, lpg_setup and lpg_pixel
//
// Bresenham line rasterizer with frame clipping. A request item with tuser
// low (start) loads two endpoints and a color and produces no response; a
// start during a line drops that line. A request item with tuser high
// (advance) produces one response item carrying the next pixel, its linear
// address row * frame_width + column, the color, a write enable in tuser
// (low outside the frame, address then zero) and tlast on the final pixel;
// an advance while no line is active is consumed with no response. The
// line state steps once per accepted advance; the pixel is clipped and
// its address formed (one 8x16 multiply and an add) into the response
// register, so one item is accepted per clock as long as the response
// register is empty or being taken in the same cycle; the response is
// offered in the cycle after its advance is accepted. The user must
// write frame_width and frame_height (reset 320 and 240) through the
// always ready csr channel, only while the block is idle (unenforced).
module line_pixel_generator_top #(
   parameter int COORD_BITS = lpg_pkg::COORD_BITS_DEF,
   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + lpg_pkg::COLOR_BITS,
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8,
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + lpg_pkg::ADDR_BITS + lpg_pkg::COLOR_BITS,
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // start_x, start_y, end_x, end_y, color
   input  logic [REQ_DATA_BITS-1:0]             req_tdata,
   // func
   input  logic                                 req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // pixel_x, pixel_y, pixel_address, pixel_color
   output logic [RSP_DATA_BITS-1:0]             rsp_tdata,
   // write_enable
   output logic                                 rsp_tuser,
   // last_pixel
   output logic                                 rsp_tlast,
   // register writes
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [lpg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [lpg_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import lpg_pkg::*;

   // frame registers
   logic [WIDTH_BITS-1:0]  frame_width_ff, frame_width_in;
   logic [HEIGHT_BITS-1:0] frame_height_ff, frame_height_in;

   lpg_cmd_type cmd;
   logic req_accept;
   logic busy, last, emit, slot_free;

   // request fields
   logic signed [COORD_BITS-1:0] start_x, start_y, end_x, end_y;
   logic [COLOR_BITS-1:0] color;

   // current pixel from the line state
   logic signed [COORD_BITS-1:0] cur_x, cur_y;
   logic [COLOR_BITS-1:0] line_color;

   // registered response fields
   logic signed [COORD_BITS-1:0] pixel_x, pixel_y;
   logic [ADDR_BITS-1:0] pixel_address;
   logic [COLOR_BITS-1:0] pixel_color;
   logic write_enable, last_pixel;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data[WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[HEIGHT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   // unpack request item, first field lowest
   assign start_x = req_tdata[0*COORD_BITS +: COORD_BITS];
   assign start_y = req_tdata[1*COORD_BITS +: COORD_BITS];
   assign end_x   = req_tdata[2*COORD_BITS +: COORD_BITS];
   assign end_y   = req_tdata[3*COORD_BITS +: COORD_BITS];
   assign color   = req_tdata[4*COORD_BITS +: COLOR_BITS];

   // a request is taken whenever the response register has room
   assign req_tready  = slot_free;
   assign req_accept  = req_tvalid && req_tready;
   assign cmd.start   = req_accept && (func_type'(req_tuser) == FUNC_START);
   assign cmd.advance = req_accept && (func_type'(req_tuser) == FUNC_ADVANCE);
   // only an advance on an active line makes a pixel
   assign emit = cmd.advance && busy;

   lpg_stepper #(.COORD_BITS(COORD_BITS)) u_stepper (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .start_x    (start_x),
      .start_y    (start_y),
      .end_x      (end_x),
      .end_y      (end_y),
      .color      (color),
      .busy       (busy),
      .pixel_x    (cur_x),
      .pixel_y    (cur_y),
      .last       (last),
      .line_color (line_color)
   );

   lpg_pixel #(.COORD_BITS(COORD_BITS)) u_pixel (
      .clock            (clock),
      .reset            (reset),
      .emit             (emit),
      .out_ready        (rsp_tready),
      .pixel_x          (cur_x),
      .pixel_y          (cur_y),
      .last             (last),
      .line_color       (line_color),
      .frame_width      (frame_width_ff),
      .frame_height     (frame_height_ff),
      .out_valid        (rsp_tvalid),
      .slot_free        (slot_free),
      .out_x            (pixel_x),
      .out_y            (pixel_y),
      .out_address      (pixel_address),
      .out_color        (pixel_color),
      .out_write_enable (write_enable),
      .out_last         (last_pixel)
   );

   // pack response item, first field lowest, zero fill to whole bytes
   assign rsp_tdata = RSP_DATA_BITS'({pixel_color, pixel_address, pixel_y, pixel_x});
   assign rsp_tuser = write_enable;
   assign rsp_tlast = last_pixel;

   // a pixel made this cycle is offered next cycle
   a_emit_shows: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_tvalid)
      else $error("pixel made but no response offered");

   // the final pixel ends the line
   a_last_idles: assert property (@(posedge clock) disable iff (reset)
      (emit && last) |=> !busy)
      else $error("line still active after its final pixel");

   // clipped pixels carry a zero address
   a_clip_addr: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (pixel_address == '0))
      else $error("clipped pixel with nonzero address");

   // written pixels never have negative coordinates
   a_we_coords: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (!pixel_x[COORD_BITS-1] && !pixel_y[COORD_BITS-1]))
      else $error("write enabled on a negative coordinate");

endmodule
